// ----- rtl/core/u8dec_pkg.sv -----
// u8dec_pkg: shared types, codes and constants of the utf-8 stream decoder
// used by u8dec_step and utf8_stream_decoder_core; no dependencies

package u8dec_pkg;

	localparam int COUNT_BITS_DEF = 16;

	localparam int BYTE_W   = 8;
	localparam int CP_W     = 21;
	localparam int CNT_W    = 18;
	localparam int REASON_W = 2;
	localparam int DEST_W   = 16;
	localparam int MODE_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_DATA_W = 48;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHAR_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_SIZE  = 2'd1;

	// character width modes
	localparam logic [MODE_W-1:0] WM_BYTE = 2'd0;
	localparam logic [MODE_W-1:0] WM_HALF = 2'd1;
	localparam logic [MODE_W-1:0] WM_FULL = 2'd2;

	// stop reasons
	localparam logic [REASON_W-1:0] STOP_NONE      = 2'd0;
	localparam logic [REASON_W-1:0] STOP_MALFORMED = 2'd1;
	localparam logic [REASON_W-1:0] STOP_TOO_WIDE  = 2'd2;
	localparam logic [REASON_W-1:0] STOP_FULL      = 2'd3;

	// code point limits
	localparam logic [CP_W-1:0] CP_MIN2    = 21'h00080;
	localparam logic [CP_W-1:0] CP_MIN3    = 21'h00800;
	localparam logic [CP_W-1:0] CP_SURR_LO = 21'h0D800;
	localparam logic [CP_W-1:0] CP_SURR_HI = 21'h0DFFF;
	localparam logic [CP_W-1:0] CP_MIN4    = 21'h10000;
	localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
	localparam logic [CP_W-1:0] CP_MAX_W0  = 21'h000FF;
	localparam logic [CP_W-1:0] CP_MAX_W1  = 21'h0FFFF;

	// stream state except the character counter
	typedef struct packed {
		logic [1:0]          conts_left;
		logic [2:0]          seq_length;
		logic [CP_W-1:0]     partial_value;
		logic [CNT_W-1:0]    byte_total;
		logic                halted;
		logic [REASON_W-1:0] halt_code;
	} dec_state_t;

	typedef struct packed {
		logic [CP_W-1:0]     code_point;
		logic                end_of_string;
		logic [CNT_W-1:0]    consumed_bytes;
		logic [REASON_W-1:0] stop_reason;
	} dec_result_t;

	typedef struct packed {
		logic        emit;
		dec_result_t res;
	} dec_out_t;

	localparam dec_state_t STATE_CLEAR = '{
		conts_left:    2'd0,
		seq_length:    3'd0,
		partial_value: '0,
		byte_total:    '0,
		halted:        1'b0,
		halt_code:     STOP_NONE
	};

endpackage

// ----- rtl/core/utf8_stream_decoder_core.sv -----
// utf8_stream_decoder_core: rfc 3629 utf-8 decoder, depends on u8dec_pkg and u8dec_step
// a result passes through the input register and then the result register before it is valid on the master side
// throughput: one byte per cycle while the master side drains results, set by the combinational
//   step logic between the input register and the result register; zero or one result per byte
// reset: arst_n clears stream state, counters and both valid flags, and loads
//   width mode 2 and destination size 65535

module utf8_stream_decoder_core #(
	parameter int COUNT_BITS = u8dec_pkg::COUNT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [u8dec_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [u8dec_pkg::CFG_DATA_W-1:0] cfg_data,
	// byte stream in
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [u8dec_pkg::BYTE_W-1:0]     s_axis_tdata,   // [7:0] in_byte
	// code point stream out
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [u8dec_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// m_axis_tdata: [20:0] code_point, [38:21] consumed_bytes,
	//   [40:39] stop_reason, [47:41] zero
	output logic                             m_axis_tlast    // end_of_string
);

	// configuration registers
	logic [u8dec_pkg::MODE_W-1:0] char_width_mode_q;
	logic [u8dec_pkg::DEST_W-1:0] dest_size_q;

	// input register
	logic                         valid_s1;
	logic [u8dec_pkg::BYTE_W-1:0] byte_s1;

	// stream state
	u8dec_pkg::dec_state_t        state_q;
	u8dec_pkg::dec_state_t        state_nxt;
	logic [COUNT_BITS-1:0]        chars_q;
	logic [COUNT_BITS-1:0]        chars_nxt;
	u8dec_pkg::dec_out_t          step_out;

	// result register
	logic                         out_valid_q;
	u8dec_pkg::dec_result_t       res_q;

	logic                         advance;

	// the byte in s1 is processed when the result register can take its result;
	// a waiting result never blocks as long as the downstream side drains it
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_width_mode_q <= u8dec_pkg::WM_FULL;
			dest_size_q       <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				u8dec_pkg::REG_CHAR_WIDTH: char_width_mode_q <= cfg_data[u8dec_pkg::MODE_W-1:0];
				u8dec_pkg::REG_DEST_SIZE:  dest_size_q       <= cfg_data[u8dec_pkg::DEST_W-1:0];
				default: ;  // unknown index, ignored
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// one byte of decoding: lead/continuation parse, range and width checks
	u8dec_step #(
		.COUNT_BITS (COUNT_BITS)
	) u_step (
		.in_byte         (byte_s1),
		.char_width_mode (char_width_mode_q),
		.dest_size       (dest_size_q),
		.cur             (state_q),
		.chars_cur       (chars_q),
		.nxt             (state_nxt),
		.chars_nxt       (chars_nxt),
		.out             (step_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= u8dec_pkg::STATE_CLEAR;
			chars_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
			chars_q <= chars_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tready)
				out_valid_q <= 1'b0;
			if (advance && step_out.emit)
				out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_out.emit) begin
			res_q <= step_out.res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = res_q.end_of_string;
	assign m_axis_tdata  = {
		(u8dec_pkg::OUT_DATA_W - u8dec_pkg::CP_W - u8dec_pkg::CNT_W - u8dec_pkg::REASON_W)'(0),
		res_q.stop_reason,
		res_q.consumed_bytes,
		res_q.code_point
	};

	// a stop reason only ever rides on the final item of a string
	a_reason_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast || res_q.stop_reason == u8dec_pkg::STOP_NONE))
		else $error("stop reason on a non-final item");

	// a halted stream holds no partial sequence and carries a real stop code
	a_halt_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.halted |-> (state_q.conts_left == 2'd0
			&& state_q.halt_code != u8dec_pkg::STOP_NONE))
		else $error("halted with a pending sequence or no stop code");

	// the terminator leaves a clean stream behind
	a_term_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && byte_s1 == '0) |=> (state_q == u8dec_pkg::STATE_CLEAR && chars_q == '0))
		else $error("stream state not cleared after terminator");

	// a continuation count always stays below the length of the open sequence
	a_seq_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.conts_left != 2'd0) |-> ({1'b0, state_q.conts_left} < state_q.seq_length))
		else $error("continuation count exceeds sequence length");

endmodule

// ----- rtl/core/u8dec_step.sv -----
// u8dec_step: next-state and result logic for one utf-8 byte
// depends on u8dec_pkg

module u8dec_step #(
	parameter int COUNT_BITS = u8dec_pkg::COUNT_BITS_DEF
) (
	input  logic [u8dec_pkg::BYTE_W-1:0] in_byte,
	input  logic [u8dec_pkg::MODE_W-1:0] char_width_mode,
	input  logic [u8dec_pkg::DEST_W-1:0] dest_size,
	input  u8dec_pkg::dec_state_t        cur,
	input  logic [COUNT_BITS-1:0]        chars_cur,
	output u8dec_pkg::dec_state_t        nxt,
	output logic [COUNT_BITS-1:0]        chars_nxt,
	output u8dec_pkg::dec_out_t          out
);

	localparam int CMP_W = (COUNT_BITS > u8dec_pkg::DEST_W) ? COUNT_BITS : u8dec_pkg::DEST_W;

	logic                         full;
	logic [u8dec_pkg::DEST_W-1:0] dest_m1;
	logic                         fin;
	logic [u8dec_pkg::CP_W-1:0]   fin_cp;
	logic [2:0]                   fin_len;
	logic                         bad;
	logic                         wide;
	logic [u8dec_pkg::CNT_W-1:0]  total_inc;
	logic [u8dec_pkg::CP_W-1:0]   merged;

	assign dest_m1 = dest_size - u8dec_pkg::DEST_W'(1);
	assign full = (dest_size == '0)
		|| (CMP_W'(chars_cur) >= CMP_W'(dest_m1))
		|| (&chars_cur);
	assign merged = {cur.partial_value[u8dec_pkg::CP_W-7:0], in_byte[5:0]};

	always_comb begin
		nxt       = cur;
		chars_nxt = chars_cur;
		out       = '0;
		fin       = 1'b0;
		fin_cp    = '0;
		fin_len   = 3'd0;
		bad       = 1'b0;
		wide      = 1'b0;
		total_inc = cur.byte_total;

		if (in_byte == '0) begin
			// terminator: final result, then a clean stream
			out.emit                   = 1'b1;
			out.res.end_of_string      = 1'b1;
			out.res.consumed_bytes     = cur.byte_total;
			if (cur.halted)
				out.res.stop_reason = cur.halt_code;
			else if (cur.conts_left != 2'd0)
				out.res.stop_reason = u8dec_pkg::STOP_MALFORMED;
			else
				out.res.stop_reason = u8dec_pkg::STOP_NONE;
			nxt       = u8dec_pkg::STATE_CLEAR;
			chars_nxt = '0;
		end else if (cur.halted) begin
			// drop bytes until the terminator
		end else if (cur.conts_left == 2'd0) begin
			if (full) begin
				nxt = u8dec_pkg::STATE_CLEAR;
				nxt.byte_total = cur.byte_total;
				nxt.halted     = 1'b1;
				nxt.halt_code  = u8dec_pkg::STOP_FULL;
			end else if (in_byte[7] == 1'b0) begin
				fin     = 1'b1;
				fin_cp  = u8dec_pkg::CP_W'(in_byte);
				fin_len = 3'd1;
			end else if (in_byte[7:5] == 3'b110) begin
				nxt.seq_length    = 3'd2;
				nxt.conts_left    = 2'd1;
				nxt.partial_value = u8dec_pkg::CP_W'(in_byte[4:0]);
			end else if (in_byte[7:4] == 4'b1110) begin
				nxt.seq_length    = 3'd3;
				nxt.conts_left    = 2'd2;
				nxt.partial_value = u8dec_pkg::CP_W'(in_byte[3:0]);
			end else if (in_byte[7:3] == 5'b11110) begin
				nxt.seq_length    = 3'd4;
				nxt.conts_left    = 2'd3;
				nxt.partial_value = u8dec_pkg::CP_W'(in_byte[2:0]);
			end else begin
				nxt = u8dec_pkg::STATE_CLEAR;
				nxt.byte_total = cur.byte_total;
				nxt.halted     = 1'b1;
				nxt.halt_code  = u8dec_pkg::STOP_MALFORMED;
			end
		end else if (in_byte[7:6] != 2'b10) begin
			nxt = u8dec_pkg::STATE_CLEAR;
			nxt.byte_total = cur.byte_total;
			nxt.halted     = 1'b1;
			nxt.halt_code  = u8dec_pkg::STOP_MALFORMED;
		end else begin
			nxt.partial_value = merged;
			nxt.conts_left    = cur.conts_left - 2'd1;
			if (cur.conts_left == 2'd1) begin
				fin     = 1'b1;
				fin_cp  = merged;
				fin_len = cur.seq_length;
			end
		end

		// character complete: range check, width check, emit
		if (fin) begin
			case (fin_len)
				3'd2: bad = fin_cp < u8dec_pkg::CP_MIN2;
				3'd3: bad = (fin_cp < u8dec_pkg::CP_MIN3)
					|| (fin_cp inside {[u8dec_pkg::CP_SURR_LO:u8dec_pkg::CP_SURR_HI]});
				3'd4: bad = (fin_cp < u8dec_pkg::CP_MIN4) || (fin_cp > u8dec_pkg::CP_MAX);
				default: bad = 1'b0;
			endcase
			wide = ((char_width_mode == u8dec_pkg::WM_BYTE) && (fin_cp > u8dec_pkg::CP_MAX_W0))
				|| ((char_width_mode == u8dec_pkg::WM_HALF) && (fin_cp > u8dec_pkg::CP_MAX_W1));
			total_inc = cur.byte_total + u8dec_pkg::CNT_W'(fin_len);
			nxt = u8dec_pkg::STATE_CLEAR;
			if (bad) begin
				nxt.byte_total = cur.byte_total;
				nxt.halted     = 1'b1;
				nxt.halt_code  = u8dec_pkg::STOP_MALFORMED;
			end else if (wide) begin
				nxt.byte_total = total_inc;
				nxt.halted     = 1'b1;
				nxt.halt_code  = u8dec_pkg::STOP_TOO_WIDE;
			end else begin
				nxt.byte_total         = total_inc;
				chars_nxt              = chars_cur + COUNT_BITS'(1);
				out.emit               = 1'b1;
				out.res.code_point     = fin_cp;
				out.res.end_of_string  = 1'b0;
				out.res.consumed_bytes = total_inc;
				out.res.stop_reason    = u8dec_pkg::STOP_NONE;
			end
		end
	end

endmodule

// ----- test/testbench.sv -----
// testbench for utf8_stream_decoder_core: random and directed utf-8 strings checked
// against a cycle-free decoder written here, over several width and capacity settings
// depends on u8dec_pkg and the decoder rtl

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import u8dec_pkg::*;

	// register indexes the block has no register for; writes there must do nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;
	// width mode 3 has no name in the package; it acts as the full width
	localparam logic [MODE_W-1:0] WM_FULL_ALT = 2'd3;

	localparam int unsigned CHAR_LIMIT = (32'd1 << COUNT_BITS_DEF) - 1;
	localparam int PHASES = 16;
	localparam int PHASE_BYTES = 100;
	localparam int LONG_HOLD = 300;
	localparam int LONG_PHASE = 4;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [BYTE_W-1:0] s_axis_tdata = '0;	// [7:0] in_byte
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;	// [20:0] code_point, [38:21] consumed_bytes,
						// [40:39] stop_reason, [47:41] zero
	logic m_axis_tlast;			// end_of_string

	utf8_stream_decoder_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#1_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ---------------------------------------------------------------
	// decoder state as the block should hold it
	// ---------------------------------------------------------------
	logic [MODE_W-1:0]   dec_mode = WM_FULL;
	logic [DEST_W-1:0]   dec_dest = 16'hFFFF;
	logic [1:0]          cur_conts = '0;
	logic [2:0]          cur_len = '0;
	logic [CP_W-1:0]     cur_partial = '0;
	int unsigned         cur_chars = 0;
	logic [CNT_W-1:0]    cur_total = '0;
	logic                cur_halted = 1'b0;
	logic [REASON_W-1:0] cur_code = STOP_NONE;

	// decoded characters and end-of-string items still to come out, oldest first
	dec_result_t due_chars[$];
	logic [BYTE_W-1:0] byte_queue[$];

	int error_count = 0;
	int bytes_queued = 0;
	int bytes_taken = 0;
	int results_seen = 0;
	int strings_done = 0;
	int reasons_seen[4] = '{0, 0, 0, 0};
	bit long_hold_req = 1'b0;

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= 20)
			$display("mismatch @%0t: %s", $realtime, msg);
	endtask

	function automatic void halt_stream(input logic [REASON_W-1:0] code);
		cur_halted = 1'b1;
		cur_code = code;
		cur_conts = '0;
		cur_len = '0;
		cur_partial = '0;
	endfunction

	// a character has all its bytes: range check, then width check, then it goes out
	function automatic void complete_char(input logic [CP_W-1:0] c, input logic [2:0] len);
		dec_result_t r;
		bit bad;
		bad = (len == 3'd2 && c < CP_MIN2) ||
			(len == 3'd3 && (c < CP_MIN3 || (c >= CP_SURR_LO && c <= CP_SURR_HI))) ||
			(len == 3'd4 && (c < CP_MIN4 || c > CP_MAX));
		if (bad) begin
			halt_stream(STOP_MALFORMED);
			return;
		end
		// a too-wide character still counts its bytes
		cur_total = cur_total + CNT_W'(len);
		if ((dec_mode == WM_BYTE && c > CP_MAX_W0) || (dec_mode == WM_HALF && c > CP_MAX_W1)) begin
			halt_stream(STOP_TOO_WIDE);
			return;
		end
		cur_chars++;
		cur_conts = '0;
		cur_len = '0;
		cur_partial = '0;
		r.code_point = c;
		r.end_of_string = 1'b0;
		r.consumed_bytes = cur_total;
		r.stop_reason = STOP_NONE;
		due_chars.push_back(r);
	endfunction

	function automatic void decode_byte(input logic [BYTE_W-1:0] b);
		dec_result_t r;
		if (b == 8'h00) begin
			// terminator: final item, then a fresh string
			r.code_point = '0;
			r.end_of_string = 1'b1;
			r.consumed_bytes = cur_total;
			if (cur_halted)
				r.stop_reason = cur_code;
			else
				r.stop_reason = (cur_conts != 0) ? STOP_MALFORMED : STOP_NONE;
			due_chars.push_back(r);
			strings_done++;
			cur_conts = '0;
			cur_len = '0;
			cur_partial = '0;
			cur_chars = 0;
			cur_total = '0;
			cur_halted = 1'b0;
			cur_code = STOP_NONE;
		end else if (!cur_halted) begin
			if (cur_conts == 0) begin
				if (dec_dest == 0 || cur_chars >= 32'(dec_dest) - 32'd1
					|| cur_chars >= CHAR_LIMIT)
					halt_stream(STOP_FULL);
				else if (b[7] == 1'b0)
					complete_char({13'd0, b}, 3'd1);
				else if (b[7:5] == 3'b110) begin
					cur_len = 3'd2;
					cur_conts = 2'd1;
					cur_partial = CP_W'(b[4:0]);
				end else if (b[7:4] == 4'b1110) begin
					cur_len = 3'd3;
					cur_conts = 2'd2;
					cur_partial = CP_W'(b[3:0]);
				end else if (b[7:3] == 5'b11110) begin
					cur_len = 3'd4;
					cur_conts = 2'd3;
					cur_partial = CP_W'(b[2:0]);
				end else
					halt_stream(STOP_MALFORMED);
			end else if (b[7:6] != 2'b10)
				halt_stream(STOP_MALFORMED);
			else begin
				cur_partial = {cur_partial[14:0], b[5:0]};
				cur_conts--;
				if (cur_conts == 0)
					complete_char(cur_partial, cur_len);
			end
		end
	endfunction

	// ---------------------------------------------------------------
	// byte sender: bursts of random length with random gaps between
	// ---------------------------------------------------------------
	int tx_gap = 0;
	int tx_burst = 1;

	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				decode_byte(s_axis_tdata);
				bytes_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap != 0) begin
					tx_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (byte_queue.size() != 0) begin
					s_axis_tdata <= byte_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					if (tx_burst <= 1) begin
						tx_burst = int'($urandom_range(1, 24));
						// a zero gap joins two bursts into a longer stretch
						tx_gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
					end else
						tx_burst--;
				end else
					s_axis_tvalid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// result receiver: checks every item, stalls in changing styles
	// ---------------------------------------------------------------
	int rx_hold = 0;
	int rx_tick = 0;
	int rx_style = 0;

	always @(posedge clk) begin
		dec_result_t got;
		dec_result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.code_point = m_axis_tdata[20:0];
				got.consumed_bytes = m_axis_tdata[38:21];
				got.stop_reason = m_axis_tdata[40:39];
				got.end_of_string = m_axis_tlast;
				results_seen++;
				if (due_chars.size() == 0)
					report_mismatch($sformatf("item %0d arrived with nothing due: cp %h last %b",
						results_seen, got.code_point, got.end_of_string));
				else begin
					want = due_chars.pop_front();
					if (want.end_of_string)
						reasons_seen[want.stop_reason]++;
					if (got.code_point !== want.code_point)
						report_mismatch($sformatf("item %0d code_point %h, want %h",
							results_seen, got.code_point, want.code_point));
					if (got.end_of_string !== want.end_of_string)
						report_mismatch($sformatf("item %0d tlast %b, want %b",
							results_seen, got.end_of_string, want.end_of_string));
					if (got.consumed_bytes !== want.consumed_bytes)
						report_mismatch($sformatf("item %0d consumed_bytes %0d, want %0d",
							results_seen, got.consumed_bytes, want.consumed_bytes));
					if (got.stop_reason !== want.stop_reason)
						report_mismatch($sformatf("item %0d stop_reason %0d, want %0d",
							results_seen, got.stop_reason, want.stop_reason));
					if (m_axis_tdata[47:41] !== '0)
						report_mismatch($sformatf("item %0d pad bits %b not zero",
							results_seen, m_axis_tdata[47:41]));
				end
			end
			// a long hold-off lets the block fill up and push back on the sender
			if (long_hold_req) begin
				rx_hold = LONG_HOLD;
				long_hold_req <= 1'b0;
			end
			if (rx_hold != 0) begin
				rx_hold--;
				m_axis_tready <= 1'b0;
			end else begin
				case (rx_style)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 3) != 0);
					2: m_axis_tready <= ((rx_tick % 3) != 0);
					default: m_axis_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
			rx_tick++;
			if (rx_tick % 101 == 0)
				rx_style = int'($urandom_range(0, 3));
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------

	// byte i of the sequence sits in bits [8*i +: 8]; lengths longer than the code point needs give overlong forms
	function automatic logic [31:0] utf8_seq(input logic [CP_W-1:0] cp, input int len);
		case (len)
			1: return {24'd0, 1'b0, cp[6:0]};
			2: return {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
			3: return {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
			default: return {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
		endcase
	endfunction

	// a legal code point of the given encoded length, never zero
	function automatic logic [CP_W-1:0] random_cp(input int len);
		logic [CP_W-1:0] cp;
		case (len)
			1: cp = CP_W'($urandom_range(1, 'h7F));
			2: cp = $urandom_range(0, 1) ? CP_W'($urandom_range('h80, 'hFF))
				: CP_W'($urandom_range('h100, 'h7FF));
			3: begin
				cp = CP_W'($urandom_range('h800, 'hFFFF));
				if (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
					cp = cp ^ 21'h2000;
			end
			default: cp = CP_W'($urandom_range('h10000, 'h10FFFF));
		endcase
		return cp;
	endfunction

	task automatic queue_bytes(input logic [31:0] seq, input int count);
		for (int i = 0; i < count; i++) begin
			byte_queue.push_back(seq[8*i +: 8]);
			bytes_queued++;
		end
	endtask

	// one character, mostly well formed; cut is set when the sequence is left open
	task automatic add_char(output bit cut);
		int len;
		int pos;
		logic [CP_W-1:0] cp;
		logic [31:0] seq;
		cut = 1'b0;
		len = int'($urandom_range(2, 4));
		seq = utf8_seq(random_cp(len), len);
		pos = int'($urandom_range(1, len - 1));
		if ($urandom_range(0, 19) < 17) begin
			len = int'($urandom_range(1, 4));
			queue_bytes(utf8_seq(random_cp(len), len), len);
		end else begin
			case ($urandom_range(0, 5))
				0: begin
					// overlong form
					cp = CP_W'($urandom_range(0, (len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF));
					queue_bytes(utf8_seq(cp, len), len);
				end
				1: queue_bytes(utf8_seq(CP_W'($urandom_range('hD800, 'hDFFF)), 3), 3);
				2: queue_bytes(utf8_seq(CP_W'($urandom_range('h110000, 'h1FFFFF)), 4), 4);
				3: queue_bytes($urandom_range(0, 1) ? $urandom_range('h80, 'hBF)
					: $urandom_range('hF8, 'hFF), 1);
				4: begin
					// continuation byte replaced by something else
					queue_bytes(seq, pos);
					queue_bytes($urandom_range(0, 1) ? $urandom_range(1, 'h7F)
						: $urandom_range('hC0, 'hFF), 1);
				end
				default: begin
					queue_bytes(seq, pos);
					cut = 1'b1;
				end
			endcase
		end
	endtask

	task automatic add_string();
		int n;
		bit cut;
		if ($urandom_range(0, 9) == 0) begin
			// noise: any nonzero bytes
			n = int'($urandom_range(1, 10));
			repeat (n) queue_bytes($urandom_range(1, 255), 1);
		end else begin
			n = int'($urandom_range(0, 12));
			for (int i = 0; i < n; i++) begin
				add_char(cut);
				if (cut)
					break;
			end
		end
		queue_bytes(32'd0, 1);
	endtask

	// registers change only with the block idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == REG_CHAR_WIDTH)
			dec_mode = data[MODE_W-1:0];
		else if (idx == REG_DEST_SIZE)
			dec_dest = data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// sender pauses until everything due has come out, then the pipe settles
	task automatic drain();
		while (byte_queue.size() != 0 || s_axis_tvalid || due_chars.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] mode_data;
		logic [CFG_DATA_W-1:0] dest_data;
		int target;
		logic [7:0] directed[] = '{
			// two one-byte characters, the smallest two-byte character, then the largest code point
			8'h41, 8'h7F, 8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00,
			// terminator inside a sequence
			8'hE0, 8'hA0, 8'h00,
			// bad lead byte, then a dropped byte
			8'hFF, 8'h41, 8'h00,
			// overlong two-byte form
			8'hC0, 8'h80, 8'h00,
			// surrogate
			8'hED, 8'hA0, 8'h80, 8'h00,
			// above the top code point
			8'hF4, 8'h90, 8'h80, 8'h80, 8'h00
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed strings under the reset settings
		foreach (directed[i])
			queue_bytes({24'd0, directed[i]}, 1);
		drain();

		for (int ph = 1; ph <= PHASES; ph++) begin
			case (ph)
				1: begin
					mode_data = CFG_DATA_W'(WM_BYTE);
					dest_data = 16'hFFFF;
				end
				2: begin
					mode_data = CFG_DATA_W'(WM_HALF);
					dest_data = 16'd0;
				end
				3: begin
					// stray upper bits must be ignored
					mode_data = {14'h3FFF, WM_FULL_ALT};
					dest_data = 16'd1;
				end
				LONG_PHASE: begin
					mode_data = CFG_DATA_W'(WM_FULL);
					dest_data = 16'hFFFF;
				end
				5: begin
					mode_data = CFG_DATA_W'(WM_FULL);
					dest_data = 16'd2;
				end
				default: begin
					mode_data = CFG_DATA_W'($urandom_range(0, 3));
					if ($urandom_range(0, 3) == 0)
						mode_data[CFG_DATA_W-1:MODE_W] = (CFG_DATA_W - MODE_W)'($urandom);
					case ($urandom_range(0, 3))
						0: dest_data = CFG_DATA_W'($urandom_range(0, 4));
						1: dest_data = CFG_DATA_W'($urandom_range(5, 40));
						2: dest_data = 16'hFFFF;
						default: dest_data = CFG_DATA_W'($urandom);
					endcase
				end
			endcase
			write_reg(REG_CHAR_WIDTH, mode_data);
			write_reg(REG_DEST_SIZE, dest_data);
			if (ph == 6)
				write_reg(REG_SPARE, CFG_DATA_W'($urandom));
			if (ph == LONG_PHASE)
				long_hold_req <= 1'b1;
			target = bytes_queued + PHASE_BYTES;
			while (bytes_queued < target)
				add_string();
			drain();
		end

		repeat (10) @(posedge clk);
		$display("%0d bytes in %0d strings over %0d register settings, %0d items checked",
			bytes_taken, strings_done, PHASES + 1, results_seen);
		$display("string ends: clean %0d, malformed %0d, too wide %0d, full %0d",
			reasons_seen[STOP_NONE], reasons_seen[STOP_MALFORMED],
			reasons_seen[STOP_TOO_WIDE], reasons_seen[STOP_FULL]);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
